// ===== design/i2crw_pkg.sv =====
// Shared types and codes for the I2C register-write master.
`timescale 1ns / 1ps
`default_nettype none

package i2crw_pkg;

    // request codes carried in the input word's tuser
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [7:0] ACK_TRIES_RESET = 8'd20;

    typedef struct packed {
        logic [1:0] req_type;
        logic [6:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] data_byte;
        logic       sda_in;
    } t_in_word;

    typedef struct packed {
        logic scl_level;
        logic sda_release;
        logic busy_res;
        logic done_res;
        logic ack_seen;
    } t_out_word;

endpackage

`default_nettype wire

// ===== design/i2crw_in_stage.sv =====
// Input register stage: holds one accepted tick word until the sequencer takes it.
`timescale 1ns / 1ps
`default_nettype none

module i2crw_in_stage (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  i2crw_pkg::t_in_word i_word,
    input  wire                 i_take,
    output logic                o_valid,
    output i2crw_pkg::t_in_word o_word
);
    import i2crw_pkg::*;

    logic     r_valid;
    t_in_word r_word;
    logic     w_accept;

    assign o_ready  = !r_valid || i_take;
    assign w_accept = i_valid && o_ready;
    assign o_valid  = r_valid;
    assign o_word   = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_word <= i_word;
        end
    end

endmodule

`default_nettype wire

// ===== design/i2crw_seq.sv =====
// Bus sequencer: start, byte bits, ack windows and stop, one step per tick word.
`timescale 1ns / 1ps
`default_nettype none

module i2crw_seq (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_wr_en,
    input  wire [7:0]            i_cfg_wr_data,
    input  wire                  i_advance,
    input  i2crw_pkg::t_in_word  i_word,
    output i2crw_pkg::t_out_word o_res
);
    import i2crw_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_START      = 4'd1,
        PH_BIT        = 4'd2,
        PH_ACK_OPEN   = 4'd3,
        PH_ACK_SAMPLE = 4'd4,
        PH_ACK_END    = 4'd5,
        PH_STOP       = 4'd6
    } t_phase;

    logic [7:0] r_ack_tries;
    t_phase     r_phase,      n_phase,      w_phase;
    logic [1:0] r_tick,       n_tick,       w_tick;
    logic [3:0] r_bit_count,  n_bit_count,  w_bit_count;
    logic [1:0] r_byte_idx,   n_byte_idx,   w_byte_idx;
    logic [7:0] r_tries_left, n_tries_left;
    logic [7:0] r_shift,      n_shift,      w_shift;
    logic [7:0] r_held_reg,   n_held_reg;
    logic [7:0] r_held_val,   n_held_val;
    logic       r_ack_flag,   n_ack_flag;
    logic [3:0] w_bit_inc;
    logic [1:0] w_byte_inc;
    t_out_word  w_res;

    always_comb begin
        // working copy after the idle/start check
        w_phase     = r_phase;
        w_tick      = r_tick;
        w_bit_count = r_bit_count;
        w_byte_idx  = r_byte_idx;
        w_shift     = r_shift;
        n_held_reg  = r_held_reg;
        n_held_val  = r_held_val;
        n_tries_left = r_tries_left;
        n_ack_flag  = r_ack_flag;

        if (i_word.req_type == REQ_CLEAR) begin
            n_ack_flag = 1'b0;
        end

        if (r_phase > PH_STOP) begin
            w_phase = PH_IDLE;
        end

        if (w_phase == PH_IDLE && i_word.req_type == REQ_START) begin
            n_held_reg  = i_word.reg_addr;
            n_held_val  = i_word.data_byte;
            w_shift     = {i_word.dev_addr, 1'b0};
            w_byte_idx  = 2'd0;
            w_bit_count = 4'd0;
            w_tick      = 2'd0;
            w_phase     = PH_START;
        end

        n_phase     = w_phase;
        n_tick      = w_tick;
        n_bit_count = w_bit_count;
        n_byte_idx  = w_byte_idx;
        n_shift     = w_shift;
        w_bit_inc   = w_bit_count + 4'd1;
        w_byte_inc  = w_byte_idx + 2'd1;

        w_res.scl_level   = 1'b1;
        w_res.sda_release = 1'b1;
        w_res.busy_res    = (w_phase != PH_IDLE);
        w_res.done_res    = 1'b0;

        unique case (w_phase)
            PH_START: begin
                w_res.scl_level   = (w_tick != 2'd3);
                w_res.sda_release = (w_tick < 2'd2);
                if (w_tick == 2'd3) begin
                    n_bit_count = 4'd0;
                    n_tick      = 2'd0;
                    n_phase     = PH_BIT;
                end else begin
                    n_tick = w_tick + 2'd1;
                end
            end
            PH_BIT: begin
                w_res.sda_release = w_shift[7];
                w_res.scl_level   = (w_tick == 2'd1) || (w_tick == 2'd2);
                if (w_tick == 2'd3) begin
                    n_shift     = {w_shift[6:0], 1'b0};
                    n_bit_count = w_bit_inc;
                    n_tick      = 2'd0;
                    if (w_bit_inc >= 4'd8) begin
                        n_phase = PH_ACK_OPEN;
                    end
                end else begin
                    n_tick = w_tick + 2'd1;
                end
            end
            PH_ACK_OPEN: begin
                w_res.scl_level = (w_tick != 2'd0);
                if (w_tick == 2'd0) begin
                    n_tick = 2'd1;
                end else begin
                    n_tick       = 2'd0;
                    n_tries_left = r_ack_tries;
                    n_phase      = PH_ACK_SAMPLE;
                end
            end
            PH_ACK_SAMPLE: begin
                // a zero try count still takes one sample
                if (!i_word.sda_in) begin
                    n_ack_flag   = 1'b1;
                    n_tries_left = 8'd0;
                    n_phase      = PH_ACK_END;
                end else if (r_tries_left <= 8'd1) begin
                    n_tries_left = 8'd0;
                    n_phase      = PH_ACK_END;
                end else begin
                    n_tries_left = r_tries_left - 8'd1;
                end
            end
            PH_ACK_END: begin
                w_res.scl_level = 1'b0;
                n_byte_idx      = w_byte_inc;
                n_tick          = 2'd0;
                if (w_byte_inc == 2'd1) begin
                    n_shift     = r_held_reg;
                    n_bit_count = 4'd0;
                    n_phase     = PH_BIT;
                end else if (w_byte_inc == 2'd2) begin
                    n_shift     = r_held_val;
                    n_bit_count = 4'd0;
                    n_phase     = PH_BIT;
                end else begin
                    n_phase = PH_STOP;
                end
            end
            PH_STOP: begin
                w_res.scl_level   = (w_tick != 2'd0);
                w_res.sda_release = (w_tick >= 2'd2);
                if (w_tick >= 2'd2) begin
                    w_res.done_res = 1'b1;
                    n_tick         = 2'd0;
                    n_phase        = PH_IDLE;
                end else begin
                    n_tick = w_tick + 2'd1;
                end
            end
            default: begin
                // idle: both lines released
            end
        endcase

        w_res.ack_seen = n_ack_flag;
    end

    assign o_res = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_tries <= ACK_TRIES_RESET;
        end else if (i_cfg_wr_en) begin
            r_ack_tries <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_tick       <= 2'd0;
            r_bit_count  <= 4'd0;
            r_byte_idx   <= 2'd0;
            r_tries_left <= 8'd0;
            r_shift      <= 8'd0;
            r_held_reg   <= 8'd0;
            r_held_val   <= 8'd0;
            r_ack_flag   <= 1'b0;
        end else if (i_advance) begin
            r_phase      <= n_phase;
            r_tick       <= n_tick;
            r_bit_count  <= n_bit_count;
            r_byte_idx   <= n_byte_idx;
            r_tries_left <= n_tries_left;
            r_shift      <= n_shift;
            r_held_reg   <= n_held_reg;
            r_held_val   <= n_held_val;
            r_ack_flag   <= n_ack_flag;
        end
    end

`ifndef NO_ASSERTIONS
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && w_res.done_res) |-> w_res.busy_res)
        else $error("done without busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && w_res.done_res) |=> (r_phase == PH_IDLE))
        else $error("sequencer not idle after stop");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count <= 4'd8)
        else $error("bit count past one byte");

    a_sample_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ACK_SAMPLE) |-> (r_tick == 2'd0))
        else $error("tick counter running in ack sample");
`endif

endmodule

`default_nettype wire

// ===== design/i2crw_out_stage.sv =====
// Output register stage: holds one result word until the downstream side takes it.
`timescale 1ns / 1ps
`default_nettype none

module i2crw_out_stage (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_load,
    input  i2crw_pkg::t_out_word i_word,
    input  wire                  i_ready,
    output logic                 o_valid,
    output i2crw_pkg::t_out_word o_word
);
    import i2crw_pkg::*;

    logic      r_valid;
    t_out_word r_word;

    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_word;
        end
    end

endmodule

`default_nettype wire

// ===== design/i2c_master_register_write.sv =====
// Top level of the I2C master that sends a three-byte register write.
// Path: an accepted tick word passes the input register, one sequencer step and the
//   output register before its result word is valid on the output.
// Throughput: one tick word per cycle; a stalled output word holds the sequencer and
//   drops s_axis_tready in the same cycle while the input register holds a word, so no word is lost or repeated.
// Reset: synchronous, active low; sequencer idle, lines released, ack flag clear,
//   ack_tries back to 20, both stages empty.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_register_write (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // tick words in
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [23:0] s_axis_tdata,  // dev_addr[6:0], reg_addr[14:7], data_byte[22:15], sda_in[23]
    input  wire  [1:0]  s_axis_tuser,  // req_type[1:0]
    // result words out
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // scl_level[0], sda_release[1], busy_res[2], ack_seen[3], zero[7:4]
    output logic        m_axis_tlast,  // done_res: last tick of the stop condition
    // ack_tries register
    input  wire         i_cfg_wr_en,
    input  wire  [7:0]  i_cfg_wr_data
);
    import i2crw_pkg::*;

    t_in_word  w_in_word;
    t_in_word  w_held_word;
    t_out_word w_res;
    t_out_word w_out_word;
    logic      w_in_valid;
    logic      w_advance;

    // unpack the stream word into fields
    assign w_in_word.req_type  = s_axis_tuser;
    assign w_in_word.dev_addr  = s_axis_tdata[6:0];
    assign w_in_word.reg_addr  = s_axis_tdata[14:7];
    assign w_in_word.data_byte = s_axis_tdata[22:15];
    assign w_in_word.sda_in    = s_axis_tdata[23];

    // a held word steps the sequencer when the output register is free or draining
    assign w_advance = w_in_valid && (!m_axis_tvalid || m_axis_tready);

    i2crw_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_word  (w_in_word),
        .i_take  (w_advance),
        .o_valid (w_in_valid),
        .o_word  (w_held_word)
    );

    i2crw_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_advance     (w_advance),
        .i_word        (w_held_word),
        .o_res         (w_res)
    );

    i2crw_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_advance),
        .i_word  (w_res),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_word  (w_out_word)
    );

    assign m_axis_tdata = {4'b0000, w_out_word.ack_seen, w_out_word.busy_res,
                           w_out_word.sda_release, w_out_word.scl_level};
    assign m_axis_tlast = w_out_word.done_res;

endmodule

`default_nettype wire
